@@ sv/rpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rpc_pkg;

    // Field widths of the point and angle formats.
    localparam int unsigned COORD_W  = 24;
    localparam int unsigned ANGLE_W  = 16;

    // Default CORDIC depth and the length of the arctangent table.
    localparam int unsigned ROTATION_STEPS_DEF = 16;
    localparam int unsigned TABLE_LEN          = 24;

    // Internal formats: the angle and the cosine/sine use 24 fraction bits.
    localparam int unsigned CS_FRAC    = 24;
    localparam int unsigned FRAC_SHIFT = 11;
    localparam int unsigned Z_W        = 27;
    localparam int unsigned XY_W       = 26;
    localparam int unsigned D_W        = COORD_W + 1;
    localparam int unsigned PROD_W     = D_W + XY_W;
    localparam int unsigned SUM_W      = PROD_W + 1;
    localparam int unsigned R_W        = SUM_W - CS_FRAC;

    localparam logic signed [ANGLE_W-1:0] PI_Q13     = ANGLE_W'(25736);
    localparam logic signed [ANGLE_W-1:0] NEG_PI_Q13 = -ANGLE_W'(25736);
    localparam logic signed [Z_W-1:0]     PI_Q24     = Z_W'(52707328);
    localparam logic signed [Z_W-1:0]     HALF_PI_Q24     = Z_W'(26353664);
    localparam logic signed [Z_W-1:0]     NEG_HALF_PI_Q24 = -Z_W'(26353664);
    localparam logic signed [XY_W-1:0]    GAIN_Q24   = XY_W'(10188014);

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // round(atan(2^-i) * 2^24)
    localparam logic signed [Z_W-1:0] ATAN_Q24 [TABLE_LEN] = '{
        Z_W'(13176795), Z_W'(7778716), Z_W'(4110060), Z_W'(2086331),
        Z_W'(1047214),  Z_W'(524117),  Z_W'(262123),  Z_W'(131069),
        Z_W'(65536),    Z_W'(32768),   Z_W'(16384),   Z_W'(8192),
        Z_W'(4096),     Z_W'(2048),    Z_W'(1024),    Z_W'(512),
        Z_W'(256),      Z_W'(128),     Z_W'(64),      Z_W'(32),
        Z_W'(16),       Z_W'(8),       Z_W'(4),       Z_W'(2)
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [ANGLE_W-1:0] angle;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] rotated_x;
        logic signed [COORD_W-1:0] rotated_y;
        logic                      saturated;
    } out_item_t;

endpackage

`default_nettype wire

@@ sv/rotate_point_about_center.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Rotates a point about a center point by a signed angle in radians.
// Input channel in_valid/in_ready/in_data carries the point, the center and
// the angle; output channel out_valid/out_ready/out_data carries the rotated
// point and a flag that is set when either coordinate was saturated.
// The angle is clamped to plus or minus pi and folded into the CORDIC range.
// The pipeline has one entry stage, one stage per CORDIC iteration
// (min(ROTATION_STEPS, 24) of them), a multiply stage and a rounding stage,
// followed by the output register.
// One item is accepted per cycle while in_ready is high, so throughput is
// one result per cycle while the receiver does not stall.
// When the receiver stalls, a one-entry skid register catches the item
// leaving the pipeline; while it is full the whole pipeline holds and
// in_ready is low. Nothing is dropped or repeated.
// Reset clears all valid bits; in_ready is high once reset is released, so a
// transfer can be taken at the first clock edge after reset.
module rotate_point_about_center #(
    parameter int unsigned ROTATION_STEPS = rpc_pkg::ROTATION_STEPS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire rpc_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output rpc_pkg::out_item_t     out_data
);

    import rpc_pkg::*;

    localparam int unsigned STEPS = (ROTATION_STEPS < TABLE_LEN) ? ROTATION_STEPS : TABLE_LEN;
    localparam int unsigned LAST  = STEPS + 2;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'd1 << (CS_FRAC - 1));

    logic en;
    logic [LAST:0] v_reg;

    // Stage registers of the entry stage and the CORDIC iterations.
    logic signed [XY_W-1:0]    x_reg    [0:STEPS];
    logic signed [XY_W-1:0]    y_reg    [0:STEPS];
    logic signed [Z_W-1:0]     z_reg    [0:STEPS];
    logic signed [D_W-1:0]     dx_reg   [0:STEPS];
    logic signed [D_W-1:0]     dy_reg   [0:STEPS];
    logic signed [COORD_W-1:0] cx_reg   [0:STEPS];
    logic signed [COORD_W-1:0] cy_reg   [0:STEPS];
    logic                      flip_reg [0:STEPS];

    // Multiply stage.
    logic signed [PROD_W-1:0]  p_xx_reg, p_yy_reg, p_xy_reg, p_yx_reg;
    logic signed [COORD_W-1:0] mcx_reg, mcy_reg;
    logic                      mflip_reg;

    // Rounding stage.
    logic signed [R_W-1:0]     rx_reg, ry_reg;
    logic signed [COORD_W-1:0] scx_reg, scy_reg;

    // Output register and skid register.
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t skid_data_reg, skid_data_next;

    assign en       = !skid_valid_reg;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[LAST-1:0], in_valid};
        end
    end

    // Entry stage: clamp the angle, widen it and fold it into +-pi/2.
    logic signed [ANGLE_W-1:0] a_cl;
    logic signed [Z_W-1:0]     z_wide, z_next;
    logic                      flip_next;

    always_comb
    begin
        if (in_data.angle > PI_Q13)
        begin
            a_cl = PI_Q13;
        end
        else if (in_data.angle < NEG_PI_Q13)
        begin
            a_cl = NEG_PI_Q13;
        end
        else
        begin
            a_cl = in_data.angle;
        end
        z_wide = Z_W'(a_cl) <<< FRAC_SHIFT;
        if (z_wide > HALF_PI_Q24)
        begin
            z_next    = z_wide - PI_Q24;
            flip_next = 1'b1;
        end
        else if (z_wide < NEG_HALF_PI_Q24)
        begin
            z_next    = z_wide + PI_Q24;
            flip_next = 1'b1;
        end
        else
        begin
            z_next    = z_wide;
            flip_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= GAIN_Q24;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_next;
            dx_reg[0]   <= D_W'(in_data.point_x) - D_W'(in_data.center_x);
            dy_reg[0]   <= D_W'(in_data.point_y) - D_W'(in_data.center_y);
            cx_reg[0]   <= in_data.center_x;
            cy_reg[0]   <= in_data.center_y;
            flip_reg[0] <= flip_next;
        end
    end

    // One CORDIC iteration per stage.
    for (genvar k = 0; k < STEPS; k++)
    begin : g_iter
        logic signed [XY_W-1:0] xs, ys, x_next, y_next;
        logic signed [Z_W-1:0]  zi_next;

        always_comb
        begin
            xs = x_reg[k] >>> k;
            ys = y_reg[k] >>> k;
            if (!z_reg[k][Z_W-1])
            begin
                x_next  = x_reg[k] - ys;
                y_next  = y_reg[k] + xs;
                zi_next = z_reg[k] - ATAN_Q24[k];
            end
            else
            begin
                x_next  = x_reg[k] + ys;
                y_next  = y_reg[k] - xs;
                zi_next = z_reg[k] + ATAN_Q24[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k+1]    <= x_next;
                y_reg[k+1]    <= y_next;
                z_reg[k+1]    <= zi_next;
                dx_reg[k+1]   <= dx_reg[k];
                dy_reg[k+1]   <= dy_reg[k];
                cx_reg[k+1]   <= cx_reg[k];
                cy_reg[k+1]   <= cy_reg[k];
                flip_reg[k+1] <= flip_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_xx_reg  <= dx_reg[STEPS] * x_reg[STEPS];
            p_yy_reg  <= dy_reg[STEPS] * y_reg[STEPS];
            p_xy_reg  <= dx_reg[STEPS] * y_reg[STEPS];
            p_yx_reg  <= dy_reg[STEPS] * x_reg[STEPS];
            mcx_reg   <= cx_reg[STEPS];
            mcy_reg   <= cy_reg[STEPS];
            mflip_reg <= flip_reg[STEPS];
        end
    end

    // A folded angle negates cosine and sine, which negates both sums.
    logic signed [SUM_W-1:0] sx, sy, ux, uy;

    always_comb
    begin
        if (mflip_reg)
        begin
            sx = SUM_W'(p_yy_reg) - SUM_W'(p_xx_reg);
            sy = SUM_W'(0) - SUM_W'(p_xy_reg) - SUM_W'(p_yx_reg);
        end
        else
        begin
            sx = SUM_W'(p_xx_reg) - SUM_W'(p_yy_reg);
            sy = SUM_W'(p_xy_reg) + SUM_W'(p_yx_reg);
        end
        ux = sx + ROUND_HALF;
        uy = sy + ROUND_HALF;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg  <= ux[SUM_W-1:CS_FRAC];
            ry_reg  <= uy[SUM_W-1:CS_FRAC];
            scx_reg <= mcx_reg;
            scy_reg <= mcy_reg;
        end
    end

    // Add the center back and saturate.
    logic signed [R_W:0] wx, wy;
    logic                hit_x, hit_y;
    out_item_t           result;

    always_comb
    begin
        wx = (R_W+1)'(rx_reg) + (R_W+1)'(scx_reg);
        wy = (R_W+1)'(ry_reg) + (R_W+1)'(scy_reg);
        hit_x = 1'b1;
        hit_y = 1'b1;
        if (wx > (R_W+1)'(COORD_MAX))
        begin
            result.rotated_x = COORD_MAX;
        end
        else if (wx < (R_W+1)'(COORD_MIN))
        begin
            result.rotated_x = COORD_MIN;
        end
        else
        begin
            result.rotated_x = wx[COORD_W-1:0];
            hit_x            = 1'b0;
        end
        if (wy > (R_W+1)'(COORD_MAX))
        begin
            result.rotated_y = COORD_MAX;
        end
        else if (wy < (R_W+1)'(COORD_MIN))
        begin
            result.rotated_y = COORD_MIN;
        end
        else
        begin
            result.rotated_y = wy[COORD_W-1:0];
            hit_y            = 1'b0;
        end
        result.saturated = hit_x | hit_y;
    end

    // Output register with a skid register behind it.
    logic out_free, push;

    assign out_free = !out_valid_reg || out_ready;
    assign push     = en && v_reg[LAST];

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = result;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The skid register only holds an item behind a waiting output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // The skid register fills only when the output was held by the receiver.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid register filled without an output stall");

    // A held pipeline keeps its valid bits.
    a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("pipeline valid bits moved while stalled");

    // A saturated result carries at least one coordinate at a range limit.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.saturated) |->
            (out_data_reg.rotated_x == COORD_MAX || out_data_reg.rotated_x == COORD_MIN ||
             out_data_reg.rotated_y == COORD_MAX || out_data_reg.rotated_y == COORD_MIN))
        else $error("saturation flag without a coordinate at its limit");

endmodule

`default_nettype wire

@@ verif/tb_rotate_point_about_center.sv @@
`timescale 1ns / 1ps

module tb_rotate_point_about_center;
    import rpc_pkg::*;

    localparam int     CLK_HALF     = 6;
    localparam int     CORDIC_ITERS = 16;
    localparam int     TAIL_CYCLES  = 40;
    localparam int     REPORT_LIMIT = 10;
    localparam int     HOLD_CYCLES  = 80;
    localparam longint TIMEOUT_NS   = 200000 * 2 * CLK_HALF;

    localparam logic signed [ANGLE_W-1:0] HALF_PI_ANGLE = 16'sd12868;
    localparam logic signed [ANGLE_W-1:0] PI_ANGLE      = 16'sd25736;

    localparam longint Z_HALF_PI    = 64'sd26353664;
    localparam longint Z_PI         = 64'sd52707328;
    localparam longint CORDIC_START = 64'sd10188014;
    localparam longint ROUND_HALF   = 64'sd8388608;
    localparam longint COORD_HI     = 64'sd8388607;
    localparam longint COORD_LO     = -64'sd8388608;

    typedef struct {
        in_item_t  item;
        bit        fixed;
        out_item_t fixed_result;
    } stim_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    // Typed-in expectation that travels alongside the current input transfer.
    logic      fixed_expected = 1'b0;
    out_item_t fixed_rotation = '0;

    longint arctan_steps [24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    stim_row_t   directed_rows[$];
    out_item_t   pending_rotations[$];
    out_item_t   oldest_rotation;
    int unsigned sender_gap_pct = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned hold_request = 0;
    int unsigned points_sent = 0;
    int unsigned rotations_checked = 0;
    int unsigned saturated_seen = 0;
    int unsigned folded_angles = 0;
    int unsigned mismatch_count = 0;

    rotate_point_about_center #(
        .ROTATION_STEPS(CORDIC_ITERS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    function automatic out_item_t rotate_about_center(input in_item_t item);
        longint    ang, z, cx, cy, dx, dy, nx, ny, xs, ys, cos_a, sin_a;
        bit        folded;
        out_item_t res;
        ang = item.angle;
        if (ang > PI_ANGLE)
            ang = PI_ANGLE;
        if (ang < -PI_ANGLE)
            ang = -PI_ANGLE;
        z = ang * 2048;
        folded = 1'b0;
        // Past a right angle the CORDIC works on the angle shifted by pi and
        // the resulting cosine and sine are negated.
        if (z > Z_HALF_PI)
        begin
            z -= Z_PI;
            folded = 1'b1;
        end
        else if (z < -Z_HALF_PI)
        begin
            z += Z_PI;
            folded = 1'b1;
        end
        cos_a = CORDIC_START;
        sin_a = 0;
        for (int i = 0; i < CORDIC_ITERS && i < 24; i++)
        begin
            xs = cos_a >>> i;
            ys = sin_a >>> i;
            if (z >= 0)
            begin
                cos_a -= ys;
                sin_a += xs;
                z -= arctan_steps[i];
            end
            else
            begin
                cos_a += ys;
                sin_a -= xs;
                z += arctan_steps[i];
            end
        end
        if (folded)
        begin
            cos_a = -cos_a;
            sin_a = -sin_a;
        end
        cx = item.center_x;
        cy = item.center_y;
        dx = longint'(item.point_x) - cx;
        dy = longint'(item.point_y) - cy;
        nx = cx + ((dx * cos_a - dy * sin_a + ROUND_HALF) >>> 24);
        ny = cy + ((dx * sin_a + dy * cos_a + ROUND_HALF) >>> 24);
        res.saturated = 1'b0;
        if (nx > COORD_HI)
        begin
            nx = COORD_HI;
            res.saturated = 1'b1;
        end
        if (nx < COORD_LO)
        begin
            nx = COORD_LO;
            res.saturated = 1'b1;
        end
        if (ny > COORD_HI)
        begin
            ny = COORD_HI;
            res.saturated = 1'b1;
        end
        if (ny < COORD_LO)
        begin
            ny = COORD_LO;
            res.saturated = 1'b1;
        end
        res.rotated_x = nx[COORD_W-1:0];
        res.rotated_y = ny[COORD_W-1:0];
        return res;
    endfunction

    function automatic void add_row(input int px, input int py, input int cx, input int cy,
                                    input int ang, input bit fixed = 1'b0,
                                    input out_item_t res = '0);
        stim_row_t row;
        row.item.point_x  = COORD_W'(px);
        row.item.point_y  = COORD_W'(py);
        row.item.center_x = COORD_W'(cx);
        row.item.center_y = COORD_W'(cy);
        row.item.angle    = ANGLE_W'(ang);
        row.fixed         = fixed;
        row.fixed_result  = res;
        directed_rows.push_back(row);
    endfunction

    function automatic logic signed [COORD_W-1:0] extreme_coord();
        logic signed [COORD_W-1:0] c;
        case ($urandom_range(5, 0))
            0:       c = COORD_MAX;
            1:       c = COORD_MIN;
            2:       c = '0;
            3:       c = '1;
            4:       c = COORD_W'(1);
            default: c = COORD_MAX - 1;
        endcase
        return c;
    endfunction

    function automatic in_item_t random_point();
        in_item_t    it;
        int          ang;
        int unsigned kind;
        kind = $urandom_range(9, 0);
        it.point_x  = COORD_W'($urandom());
        it.point_y  = COORD_W'($urandom());
        it.center_x = COORD_W'($urandom());
        it.center_y = COORD_W'($urandom());
        it.angle    = ANGLE_W'($urandom());
        case (kind)
            0, 1, 2, 3:
            begin
                // Ordinary use: a point near the center, angle within one half turn.
                it.point_x = it.center_x + COORD_W'(int'($urandom_range(131072, 0)) - 65536);
                it.point_y = it.center_y + COORD_W'(int'($urandom_range(131072, 0)) - 65536);
                it.angle   = ANGLE_W'(int'($urandom_range(2 * 25736, 0)) - 25736);
            end
            6:
            begin
                it.point_x  = COORD_W'(int'($urandom_range(8191, 0)) - 4096);
                it.point_y  = COORD_W'(int'($urandom_range(8191, 0)) - 4096);
                it.center_x = COORD_W'(int'($urandom_range(8191, 0)) - 4096);
                it.center_y = COORD_W'(int'($urandom_range(8191, 0)) - 4096);
                case ($urandom_range(4, 0))
                    0:       ang = 0;
                    1:       ang = HALF_PI_ANGLE;
                    2:       ang = PI_ANGLE;
                    3:       ang = 32767;
                    default: ang = -32768;
                endcase
                if (ang < 32767 && ang > -32768)
                begin
                    if ($urandom_range(1, 0) == 1)
                        ang = -ang;
                    ang = ang + int'($urandom_range(2, 0)) - 1;
                end
                it.angle = ANGLE_W'(ang);
            end
            7:
            begin
                it.point_x  = extreme_coord();
                it.point_y  = extreme_coord();
                it.center_x = extreme_coord();
                it.center_y = extreme_coord();
            end
            8, 9:
            begin
                it.point_x  = COORD_W'(int'($urandom_range(8191, 0)) - 4096);
                it.point_y  = COORD_W'(int'($urandom_range(8191, 0)) - 4096);
                it.center_x = COORD_W'(int'($urandom_range(2097151, 0)) - 1048576);
                it.center_y = COORD_W'(int'($urandom_range(2097151, 0)) - 1048576);
            end
            default:
            begin
            end
        endcase
        return it;
    endfunction

    // Ends right after the rising edge at which the point was taken.
    task automatic offer_point(input in_item_t item, input bit fixed, input out_item_t res);
        @(negedge clk);
        while (sender_gap_pct != 0 && $urandom_range(99, 0) < sender_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        in_data        <= item;
        fixed_expected <= fixed;
        fixed_rotation <= res;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count) offer_point(random_point(), 1'b0, '0);
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        in_valid       <= 1'b0;
        fixed_expected <= 1'b0;
        while (pending_rotations.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Receiver side: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_request) @(negedge clk);
                hold_request = 0;
            end
            out_ready <= (receiver_stall_pct == 0) ||
                         ($urandom_range(99, 0) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_rotations.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected rotation transfer: x=%0d y=%0d sat=%0d",
                                 out_data.rotated_x, out_data.rotated_y, out_data.saturated);
                end
                else
                begin
                    oldest_rotation = pending_rotations.pop_front();
                    rotations_checked++;
                    if (oldest_rotation.saturated)
                        saturated_seen++;
                    if (out_data.rotated_x !== oldest_rotation.rotated_x ||
                        out_data.rotated_y !== oldest_rotation.rotated_y ||
                        out_data.saturated !== oldest_rotation.saturated)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("rotation %0d mismatch: expected x=%0d y=%0d sat=%0d, got x=%0d y=%0d sat=%0d",
                                     rotations_checked, oldest_rotation.rotated_x,
                                     oldest_rotation.rotated_y, oldest_rotation.saturated,
                                     out_data.rotated_x, out_data.rotated_y,
                                     out_data.saturated);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                points_sent++;
                if (in_data.angle > HALF_PI_ANGLE || in_data.angle < -HALF_PI_ANGLE)
                    folded_angles++;
                if (fixed_expected)
                    pending_rotations.push_back(fixed_rotation);
                else
                    pending_rotations.push_back(rotate_about_center(in_data));
            end
        end
    end

    initial
    begin
        sender_gap_pct     = 30;
        receiver_stall_pct = 59;

        // Point on the center stays put, whatever the angle.
        add_row(0, 0, 0, 0, 0, 1'b1, '0);
        add_row(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 32767, 1'b1,
                {COORD_MAX, COORD_MAX, 1'b0});
        add_row(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, -32768, 1'b1,
                {COORD_MIN, COORD_MIN, 1'b0});
        add_row(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, PI_ANGLE, 1'b1,
                {COORD_MAX, COORD_MIN, 1'b0});
        add_row(256, 0, 0, 0, 0);
        add_row(256, 0, 0, 0, PI_ANGLE);
        add_row(256, 0, 0, 0, -PI_ANGLE);
        add_row(256, 0, 0, 0, 25737);
        add_row(256, 0, 0, 0, -25737);
        add_row(1000, -700, 300, 200, HALF_PI_ANGLE);
        add_row(1000, -700, 300, 200, -HALF_PI_ANGLE);
        add_row(1000, -700, 300, 200, 12869);
        add_row(1000, -700, 300, 200, -12869);
        add_row(COORD_MAX, 0, COORD_MIN, 0, PI_ANGLE);
        add_row(COORD_MAX, 0, 0, COORD_MAX, HALF_PI_ANGLE);
        add_row(COORD_MIN, 0, COORD_MAX, 0, 0);
        add_row(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, -20000);
        add_row(5000, -3000, 100, 100, 32767);
        add_row(5000, -3000, 100, 100, -32768);
        add_row(-1, -1, 0, 0, 1);
        add_row(1, 0, 0, 0, -1);
        add_row(COORD_MIN, COORD_MAX, -1, 0, 6434);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
            offer_point(directed_rows[r].item, directed_rows[r].fixed,
                        directed_rows[r].fixed_result);
        send_random(320);
        wait_for_drain();

        sender_gap_pct     = 59;
        receiver_stall_pct = 30;
        send_random(320);
        wait_for_drain();

        // No idling; the receiver first holds off long enough for the
        // pipeline and its skid entry to fill and stall the input.
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        hold_request       = HOLD_CYCLES;
        send_random(60);
        send_random(250);
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Rotated %0d points (%0d from the directed table), checked %0d results.",
                 points_sent, directed_rows.size(), rotations_checked);
        $display("%0d results saturated, %0d angles folded past a right angle, %0d mismatches.",
                 saturated_seen, folded_angles, mismatch_count);
        if (mismatch_count == 0 && pending_rotations.size() == 0)
            $display("tb_rotate_point_about_center OK");
        else
            $display("tb_rotate_point_about_center NOT OK");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", pending_rotations.size());
        $display("tb_rotate_point_about_center NOT OK");
        $finish;
    end

endmodule
